FILE: hdl/bmpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bmpd_pkg;
  localparam int PaletteDepth = 256;
  localparam int PalAw = $clog2(PaletteDepth);
  localparam logic [22:0] MaxPixels = 23'd4194304;

  typedef enum logic [2:0] {
    FMT_1BIT = 3'd0, FMT_4BIT = 3'd1, FMT_8BIT = 3'd2, FMT_24BIT = 3'd3,
    FMT_32BIT = 3'd4, FMT_RLE8 = 3'd5, FMT_RLE4 = 3'd6, FMT_NONE = 3'd7
  } fmt_t;

  localparam logic [1:0] MODE_PAL = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_TOTAL = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0, PH_SECOND = 2'd1, PH_ABS = 2'd2, PH_PAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic [7:0] run_length;
    logic image_done;
    logic item_last;
  } out_beat_t;

  // classified work for the back end
  typedef struct packed {
    logic       pal_wr;      // palette entry write: idx1 and color
    logic       hit;         // run reaches the pixel limit
    logic       is_bits;     // 1-bit format: up to eight pixels
    logic       direct;      // color carried in color field
    logic [7:0] idx1;
    logic [7:0] idx2;
    logic [23:0] color;
    logic [7:0] len;
  } cmd_t;
endpackage
`default_nettype wire

FILE: hdl/bmp_pixel_stream_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake
// cfg     | in  | cfg_write, no stall
// in      | in  | in_valid / in_stall
// out     | out | out_valid / out_stall
// one input beat per cycle while in_stall is low; results pass queue, cur and s1 registers
// the 1-bit format gives up to eight result beats per input beat, one per unstalled cycle
// a two-entry command queue parts parser and palette lookup; in_stall is high while it is full
// rst is synchronous and clears parse state, counters and valid flags, not data or the palette
module bmp_pixel_stream_decoder_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [22:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire bmpd_pkg::in_beat_t   in_beat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bmpd_pkg::out_beat_t       out_beat
);
  import bmpd_pkg::*;
  logic take, cv, push, pop;
  cmd_t c, q0, q1, q0_next, q1_next;
  logic [1:0] cnt, cnt_next;

  assign in_stall = (cnt == 2'd2);
  assign take = in_valid && !in_stall;
  assign push = take && cv;

  bmpd_front u_front (.clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index[0]),
    .cfg_data(cfg_data), .take(take), .beat(in_beat), .cmd_valid(cv), .cmd(c));

  always_comb begin
    q0_next = q0;
    q1_next = q1;
    if (pop) q0_next = q1;
    if (push) begin
      if (cnt == 2'd0 || (cnt == 2'd1 && pop)) q0_next = c;
      else q1_next = c;
    end
    cnt_next = cnt + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= 2'd0;
    else cnt <= cnt_next;
    q0 <= q0_next;
    q1 <= q1_next;
  end

  bmpd_back u_back (.clk(clk), .rst(rst), .q_valid(cnt != 2'd0), .q_cmd(q0), .q_pop(pop),
    .out_valid(out_valid), .out_beat(out_beat), .out_stall(out_stall));
`ifndef SYNTHESIS
  a_pop: assert property (@(posedge clk) disable iff (rst) pop |-> cnt != 2'd0)
    else $error("pop from empty queue");
  a_push: assert property (@(posedge clk) disable iff (rst) push |-> cnt != 2'd2)
    else $error("push into full queue");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("stalled output beat changed");
`endif
endmodule
`default_nettype wire

FILE: hdl/bmpd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bmpd_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/bmpd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bmpd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [22:0]        cfg_data,
  input  wire logic               take,
  input  wire bmpd_pkg::in_beat_t beat,
  output logic                    cmd_valid,
  output bmpd_pkg::cmd_t          cmd
);
  import bmpd_pkg::*;

  fmt_t        fmt;
  logic [22:0] total;
  logic [22:0] done;
  phase_t      phase;
  logic [7:0]  held;
  logic [7:0]  left;
  logic        parity;
  logic [15:0] hcol;
  logic [1:0]  bip;

  fmt_t        fmt_next;
  logic [22:0] total_next, done_next;
  phase_t      phase_next;
  logic [7:0]  held_next, left_next;
  logic        parity_next;
  logic [15:0] hcol_next;
  logic [1:0]  bip_next;

  logic [22:0] lim, room;
  logic [7:0]  want, len_cut, k, b;
  logic        four, emit, palw;
  logic [8:0]  bp1;

  assign lim = (total > MaxPixels) ? MaxPixels : total;
  assign room = (done < lim) ? lim - done : 23'd0;
  assign b = beat.data_byte;
  assign four = (fmt == FMT_RLE4);
  assign bp1 = {1'b0, b} + 9'd1;

  always_comb begin
    fmt_next = fmt; total_next = total; done_next = done; phase_next = phase;
    held_next = held; left_next = left; parity_next = parity; hcol_next = hcol;
    bip_next = bip; want = 8'd0; k = 8'd0; emit = 1'b0; palw = 1'b0;
    cmd = '0;
    if (cfg_write) begin
      if (cfg_index == REG_FORMAT) begin
        fmt_next = fmt_t'(cfg_data[2:0]);
        phase_next = PH_FIRST; held_next = '0; left_next = '0; parity_next = 1'b0;
        hcol_next = '0; bip_next = '0;
      end else begin
        total_next = cfg_data;
      end
    end else if (take && beat.mode == MODE_PAL) begin
      if ({1'b0, beat.palette_index} < 9'(PaletteDepth)) begin
        palw = 1'b1; cmd.pal_wr = 1'b1; cmd.idx1 = beat.palette_index;
        cmd.color = {beat.palette_red, beat.palette_green, beat.palette_blue};
      end
    end else if (take && beat.mode == MODE_START) begin
      done_next = '0; phase_next = PH_FIRST; held_next = '0; left_next = '0;
      parity_next = 1'b0; hcol_next = '0; bip_next = '0;
    end else if (take && beat.mode == MODE_DATA && done < lim) begin
      unique case (fmt)
        FMT_1BIT: begin emit = 1'b1; want = 8'd8; cmd.is_bits = 1'b1; cmd.idx1 = b; end
        FMT_4BIT: begin emit = 1'b1; want = 8'd2; cmd.idx1 = {4'd0, b[7:4]};
                        cmd.idx2 = {4'd0, b[3:0]}; end
        FMT_8BIT: begin emit = 1'b1; want = 8'd1; cmd.idx1 = b; cmd.idx2 = b; end
        FMT_24BIT, FMT_32BIT: begin
          unique case (bip)
            2'd0: begin hcol_next = {8'd0, b}; bip_next = 2'd1; end
            2'd1: begin hcol_next = {b, hcol[7:0]}; bip_next = 2'd2; end
            2'd2: begin
              emit = 1'b1; want = 8'd1; cmd.direct = 1'b1; cmd.color = {b, hcol};
              bip_next = (fmt == FMT_32BIT) ? 2'd3 : 2'd0;
            end
            default: bip_next = 2'd0;
          endcase
        end
        FMT_RLE8, FMT_RLE4: begin
          cmd.idx1 = four ? {4'd0, b[7:4]} : b;
          cmd.idx2 = four ? {4'd0, b[3:0]} : b;
          unique case (phase)
            PH_FIRST: begin held_next = b; phase_next = PH_SECOND; end
            PH_SECOND: begin
              if (held == 8'd0) begin
                if (b == 8'd0) phase_next = PH_FIRST;
                else begin
                  left_next = b; parity_next = four ? bp1[1] : b[0];
                  phase_next = PH_ABS;
                end
              end else begin
                emit = 1'b1; want = held; phase_next = PH_FIRST;
              end
            end
            PH_ABS: begin
              if (four) k = (left >= 8'd2) ? 8'd2 : left;
              else k = (left != 8'd0) ? 8'd1 : 8'd0;
              emit = 1'b1; want = k; left_next = left - k;
              if (left - k == 8'd0) phase_next = parity ? PH_PAD : PH_FIRST;
            end
            default: phase_next = PH_FIRST;
          endcase
        end
        default: ;
      endcase
    end
    len_cut = ({15'd0, want} > room) ? room[7:0] : want;
    cmd.len = len_cut;
    cmd.hit = (done + {15'd0, len_cut}) >= lim;
    if (emit) done_next = done + {15'd0, len_cut};
  end

  // a queue entry exists only when pixels remain to deliver or a palette write
  assign cmd_valid = palw || (emit && len_cut != 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_8BIT; total <= 23'd1; done <= '0; phase <= PH_FIRST;
      held <= '0; left <= '0; parity <= 1'b0; hcol <= '0; bip <= '0;
    end else begin
      fmt <= fmt_next; total <= total_next; done <= done_next; phase <= phase_next;
      held <= held_next; left <= left_next; parity <= parity_next;
      hcol <= hcol_next; bip <= bip_next;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/bmpd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bmpd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire bmpd_pkg::cmd_t      q_cmd,
  output logic                     q_pop,
  output logic                     out_valid,
  output bmpd_pkg::out_beat_t      out_beat,
  input  wire logic                out_stall
);
  import bmpd_pkg::*;

  cmd_t             cur;
  logic             busy, adv, we, rd, step, lastbit, load, bitv, ok1, ok2;
  logic [3:0]       bitpos;
  logic [PalAw-1:0] a1, a2;
  logic [23:0]      c1, c2, p1, p2;

  // stage 0: hold a command, walk its bits; stage 1: registered palette read
  logic        s1_valid, s1_last, s1_hit, s1_direct, s1_bits, s1_ok1, s1_ok2;
  logic [23:0] s1_color;
  logic [7:0]  s1_len;

  assign adv = !s1_valid || !out_stall;
  assign we = busy && cur.pal_wr;
  assign rd = busy && !cur.pal_wr && adv;
  assign step = we || rd;
  // the bit stream was cut to len pixels already
  assign lastbit = cur.is_bits ? (bitpos == cur.len[3:0] - 4'd1) : 1'b1;
  assign load = !busy || (step && lastbit);
  assign q_pop = load && q_valid;

  assign bitv = cur.idx1[3'd7 - bitpos[2:0]];
  assign a1 = cur.is_bits ? PalAw'(bitv) : cur.idx1[PalAw-1:0];
  assign a2 = cur.idx2[PalAw-1:0];
  assign ok1 = cur.is_bits || {1'b0, cur.idx1} < 9'(PaletteDepth);
  assign ok2 = {1'b0, cur.idx2} < 9'(PaletteDepth);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; bitpos <= '0;
    end else if (load) begin
      busy <= q_valid; bitpos <= '0;
    end else if (step) begin
      bitpos <= bitpos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur <= q_cmd;
  end

  bmpd_ram #(.Width(24), .Depth(PaletteDepth)) u_ram_a (
    .clk(clk), .we(we), .waddr(cur.idx1[PalAw-1:0]), .wdata(cur.color),
    .re(rd), .raddr(a1), .rdata(c1));
  bmpd_ram #(.Width(24), .Depth(PaletteDepth)) u_ram_b (
    .clk(clk), .we(we), .waddr(cur.idx1[PalAw-1:0]), .wdata(cur.color),
    .re(rd), .raddr(a2), .rdata(c2));

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= rd;
    if (adv) begin
      s1_last <= lastbit; s1_hit <= cur.hit && lastbit; s1_direct <= cur.direct;
      s1_ok1 <= ok1; s1_ok2 <= ok2; s1_bits <= cur.is_bits; s1_color <= cur.color;
      s1_len <= cur.is_bits ? 8'd1 : cur.len;
    end
  end

  assign out_valid = s1_valid;

  always_comb begin
    p1 = s1_direct ? s1_color : (s1_ok1 ? c1 : 24'd0);
    if (s1_direct || s1_bits) p2 = p1;
    else p2 = s1_ok2 ? c2 : 24'd0;
    out_beat.first_red = p1[23:16];
    out_beat.first_green = p1[15:8];
    out_beat.first_blue = p1[7:0];
    out_beat.second_red = p2[23:16];
    out_beat.second_green = p2[15:8];
    out_beat.second_blue = p2[7:0];
    out_beat.run_length = s1_len;
    out_beat.image_done = s1_hit;
    out_beat.item_last = s1_last;
  end
endmodule
`default_nettype wire
